FILE: hw/rtl/ring_interval_union_table_top_assert.svh
// Assertion macros for the interval table block.
`ifndef RING_INTERVAL_UNION_TABLE_TOP_ASSERT_SVH
`define RING_INTERVAL_UNION_TABLE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RITU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ritu check failed");
`define RITU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("ritu check failed");
`else
`define RITU_ASSERT(lbl, clk, rst, prop)
`define RITU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/ritu_pkg.sv
`default_nettype none
package ritu_pkg;
  localparam int MAX_INTERVALS = 16;
  localparam int COORD_BITS    = 16;
  localparam int COUNT_W       = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W         = 4;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam count_t MAX_COUNT = count_t'(MAX_INTERVALS);
  localparam coord_t RING_SIZE_RESET = coord_t'(65535);

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

  // register index of ring_size (byte address bit 2)
  localparam logic REG_RING_SIZE = 1'b0;

  typedef enum logic [1:0] {S_IDLE, S_PLACE, S_ABSORB, S_FINISH} state_t;

  typedef enum logic [2:0] {
    CELL_HOLD, CELL_LOAD, CELL_FROM_LEFT, CELL_FROM_RIGHT, CELL_ABSORB
  } cell_op_t;

  typedef enum logic [1:0] {CH_HOLD, CH_PLACE, CH_ABSORB} chain_mode_t;

  typedef struct packed {
    chain_mode_t mode;
    coord_t      s;
    coord_t      e;
    count_t      count;
    idx_t        cur;
    idx_t        rd_idx;
  } chain_cmd_t;

  typedef struct packed {
    logic   touched;
    idx_t   pos_idx;
    logic   can_absorb;
    coord_t rd_lo;
    coord_t rd_hi;
  } chain_st_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ritu_ifs.sv
`default_nettype none
interface ritu_req_if;
  logic                        valid;
  logic                        ready;
  logic [ritu_pkg::OP_W-1:0]   operation;
  ritu_pkg::coord_t            span_start;
  ritu_pkg::coord_t            span_length;
  ritu_pkg::idx_t              entry_index;
  modport source (output valid, operation, span_start, span_length, entry_index,
                  input ready);
  modport sink   (input valid, operation, span_start, span_length, entry_index,
                  output ready);
endinterface

interface ritu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ritu_pkg::ST_W-1:0]   status;
  ritu_pkg::count_t            interval_count;
  ritu_pkg::coord_t            entry_begin;
  ritu_pkg::coord_t            entry_end;
  modport source (output valid, status, interval_count, entry_begin, entry_end,
                  input ready);
  modport sink   (input valid, status, interval_count, entry_begin, entry_end,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ritu_cell.sv
`default_nettype none
// One table entry; takes new data from the load bus or a neighbor.
module ritu_cell (
  input  wire logic               clk,
  input  ritu_pkg::cell_op_t      op,
  input  ritu_pkg::coord_t        load_lo,
  input  ritu_pkg::coord_t        load_hi,
  input  ritu_pkg::coord_t        left_lo,
  input  ritu_pkg::coord_t        left_hi,
  input  ritu_pkg::coord_t        right_lo,
  input  ritu_pkg::coord_t        right_hi,
  output ritu_pkg::coord_t        iv_lo,
  output ritu_pkg::coord_t        iv_hi
);
  always_ff @(posedge clk) begin
    unique case (op)
      ritu_pkg::CELL_LOAD: begin
        iv_lo <= load_lo;
        iv_hi <= load_hi;
      end
      ritu_pkg::CELL_FROM_LEFT: begin
        iv_lo <= left_lo;
        iv_hi <= left_hi;
      end
      ritu_pkg::CELL_FROM_RIGHT: begin
        iv_lo <= right_lo;
        iv_hi <= right_hi;
      end
      // join right neighbor: end is the larger one
      ritu_pkg::CELL_ABSORB: begin
        if (right_hi > iv_hi) iv_hi <= right_hi;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ritu_chain.sv
`default_nettype none
`include "ring_interval_union_table_top_assert.svh"
// Row of entry cells plus per-cell placement flags.
module ritu_chain (
  input  wire logic             clk,
  input  wire logic             rst,
  input  ritu_pkg::chain_cmd_t  cmd,
  output ritu_pkg::chain_st_t   st
);
  localparam int N = ritu_pkg::MAX_INTERVALS;

  ritu_pkg::coord_t   lo [N];
  ritu_pkg::coord_t   hi [N];
  ritu_pkg::coord_t   l_lo [N];
  ritu_pkg::coord_t   l_hi [N];
  ritu_pkg::coord_t   r_lo [N];
  ritu_pkg::coord_t   r_hi [N];
  ritu_pkg::coord_t   ld_lo [N];
  ritu_pkg::coord_t   ld_hi [N];
  ritu_pkg::cell_op_t op [N];

  logic [N-1:0] valid, prior, prior_sh, pos, touch, at_cur, above_cur, absorb_ok;
  logic         touched, can_absorb, full;
  ritu_pkg::idx_t pos_idx;

  // neighbor wiring
  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign l_lo[k] = lo[k];
      assign l_hi[k] = hi[k];
    end else begin : g_left
      assign l_lo[k] = lo[k-1];
      assign l_hi[k] = hi[k-1];
    end
    if (k == N-1) begin : g_last
      assign r_lo[k] = lo[k];
      assign r_hi[k] = hi[k];
    end else begin : g_right
      assign r_lo[k] = lo[k+1];
      assign r_hi[k] = hi[k+1];
    end
    ritu_cell u_cell (
      .clk      (clk),
      .op       (op[k]),
      .load_lo  (ld_lo[k]),
      .load_hi  (ld_hi[k]),
      .left_lo  (l_lo[k]),
      .left_hi  (l_hi[k]),
      .right_lo (r_lo[k]),
      .right_hi (r_hi[k]),
      .iv_lo    (lo[k]),
      .iv_hi    (hi[k])
    );
  end

  // per-cell flags: entries before the span form a prefix
  always_comb begin
    for (int k = 0; k < N; k++) begin
      valid[k]     = ritu_pkg::count_t'(k) < cmd.count;
      prior[k]     = valid[k] && (hi[k] < cmd.s);
      at_cur[k]    = ritu_pkg::idx_t'(k) == cmd.cur;
      above_cur[k] = ritu_pkg::idx_t'(k) > cmd.cur;
      absorb_ok[k] = (ritu_pkg::count_t'(k + 1) < cmd.count) && (r_lo[k] <= hi[k]);
    end
  end
  assign prior_sh = {prior[N-2:0], 1'b1};
  assign pos      = ~prior & prior_sh;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      touch[k] = pos[k] && valid[k] && (cmd.e >= lo[k]);
    end
  end
  assign touched    = |touch;
  assign can_absorb = |(at_cur & absorb_ok);
  assign full       = cmd.count == ritu_pkg::MAX_COUNT;

  // index of the placement cell
  always_comb begin
    pos_idx = '0;
    for (int k = 0; k < N; k++) begin
      pos_idx = pos_idx | (pos[k] ? ritu_pkg::idx_t'(k) : '0);
    end
  end

  // cell commands
  always_comb begin
    for (int k = 0; k < N; k++) begin
      ld_lo[k] = (touched && lo[k] < cmd.s) ? lo[k] : cmd.s;
      ld_hi[k] = (touched && hi[k] > cmd.e) ? hi[k] : cmd.e;
      op[k]    = ritu_pkg::CELL_HOLD;
      unique case (cmd.mode)
        ritu_pkg::CH_PLACE: begin
          if (pos[k] && (touched || !full)) op[k] = ritu_pkg::CELL_LOAD;
          else if (!touched && !full && !prior_sh[k]) op[k] = ritu_pkg::CELL_FROM_LEFT;
        end
        ritu_pkg::CH_ABSORB: begin
          if (can_absorb && at_cur[k]) op[k] = ritu_pkg::CELL_ABSORB;
          else if (can_absorb && above_cur[k]) op[k] = ritu_pkg::CELL_FROM_RIGHT;
        end
        default: begin
        end
      endcase
    end
  end

  assign st.touched    = touched;
  assign st.pos_idx    = pos_idx;
  assign st.can_absorb = can_absorb;
  assign st.rd_lo      = lo[cmd.rd_idx];
  assign st.rd_hi      = hi[cmd.rd_idx];

  `RITU_ASSERT(a_pos_single, clk, rst, $onehot0(pos))
  `RITU_ASSERT(a_touch_in_table, clk, rst, !touched || ({1'b0, pos_idx} < cmd.count))
  `RITU_ASSERT(a_prior_prefix, clk, rst, (prior & ~prior_sh) == '0)
endmodule
`default_nettype wire

FILE: hw/rtl/ring_interval_union_table_top.sv
`default_nettype none
`include "ring_interval_union_table_top_assert.svh"
// Channel | Dir | Handshake      | Word
// req     | in  | valid/ready    | operation, span_start, span_length, entry_index
// rsp     | out | valid/ready    | status, interval_count, entry_begin, entry_end
// apb     | in  | psel/penable   | ring_size at byte address 0
//
// One item at a time. Read, clear and invalid items pass from idle to the finish
// state, which loads the result into the output register and returns to idle.
// An add passes, per part (two for a wrapped span), through the placement
// state and, when the part touches an entry, the absorb state, which joins
// entries until it sees the end of the run; the cell row joins one neighbor
// per cycle.
// rst is synchronous; the table comes up empty with no clearing pass.
// A waiting result holds in the output register; the next item is accepted
// as soon as the block is back in idle.
module ring_interval_union_table_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ritu_req_if.sink                           req,
  ritu_rsp_if.source                         rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ritu_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ritu_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ritu_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  ritu_pkg::state_t   state, state_next;
  ritu_pkg::coord_t   ring_size;
  ritu_pkg::count_t   count;
  ritu_pkg::coord_t   s, e, e2;
  logic               pending;
  logic [ritu_pkg::ST_W-1:0] status;
  logic [ritu_pkg::OP_W-1:0] op;
  ritu_pkg::idx_t     idx, cur;
  logic               rsp_valid;
  logic [ritu_pkg::ST_W-1:0] rsp_status;
  ritu_pkg::count_t   rsp_count;
  ritu_pkg::coord_t   rsp_begin, rsp_end;

  ritu_pkg::chain_cmd_t  cmd;
  ritu_pkg::chain_st_t   cst;
  ritu_pkg::chain_mode_t mode;

  logic accept, load_out, bad_span, wrap, read_ok, full;
  logic [ritu_pkg::COORD_BITS:0] sum, rest;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ritu_pkg::REG_RING_SIZE) ?
                  ritu_pkg::PDATA_W'(ring_size) : '0;
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= ritu_pkg::RING_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ritu_pkg::REG_RING_SIZE) begin
      ring_size <= pwdata[ritu_pkg::COORD_BITS-1:0];
    end
  end

  // span decode
  assign sum      = {1'b0, req.span_start} + {1'b0, req.span_length};
  assign rest     = sum - {1'b0, ring_size};
  assign bad_span = (req.span_length == '0) || (req.span_start >= ring_size);
  assign wrap     = sum > {1'b0, ring_size};
  assign full     = count == ritu_pkg::MAX_COUNT;
  assign read_ok  = {1'b0, idx} < count;
  assign accept   = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ritu_pkg::S_IDLE: begin
        if (accept) begin
          if (req.operation == ritu_pkg::OP_ADD && !bad_span) state_next = ritu_pkg::S_PLACE;
          else state_next = ritu_pkg::S_FINISH;
        end
      end
      ritu_pkg::S_PLACE: begin
        if (cst.touched) state_next = ritu_pkg::S_ABSORB;
        else if (full || !pending) state_next = ritu_pkg::S_FINISH;
      end
      ritu_pkg::S_ABSORB: begin
        if (!cst.can_absorb) state_next = pending ? ritu_pkg::S_PLACE : ritu_pkg::S_FINISH;
      end
      ritu_pkg::S_FINISH: begin
        if (!rsp_valid || rsp.ready) state_next = ritu_pkg::S_IDLE;
      end
      default: state_next = ritu_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    mode      = ritu_pkg::CH_HOLD;
    unique case (state)
      ritu_pkg::S_IDLE:   req.ready = 1'b1;
      ritu_pkg::S_PLACE:  mode      = ritu_pkg::CH_PLACE;
      ritu_pkg::S_ABSORB: mode      = ritu_pkg::CH_ABSORB;
      ritu_pkg::S_FINISH: load_out  = !rsp_valid || rsp.ready;
      default: begin
      end
    endcase
  end

  assign cmd.mode   = mode;
  assign cmd.s      = s;
  assign cmd.e      = e;
  assign cmd.count  = count;
  assign cmd.cur    = cur;
  assign cmd.rd_idx = idx;

  ritu_chain u_chain (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .st  (cst)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ritu_pkg::S_IDLE;
      count     <= '0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        ritu_pkg::S_IDLE: begin
          if (accept) begin
            pending <= (req.operation == ritu_pkg::OP_ADD) && !bad_span && wrap;
            if (req.operation == ritu_pkg::OP_CLEAR) count <= '0;
          end
        end
        ritu_pkg::S_PLACE: begin
          if (!cst.touched) begin
            if (full) pending <= 1'b0;
            else begin
              count   <= count + 1'b1;
              pending <= 1'b0;
            end
          end
        end
        ritu_pkg::S_ABSORB: begin
          if (cst.can_absorb) count <= count - 1'b1;
          else pending <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    unique case (state)
      ritu_pkg::S_IDLE: begin
        if (accept) begin
          op  <= req.operation;
          idx <= req.entry_index;
          s   <= req.span_start;
          e   <= wrap ? ring_size : sum[ritu_pkg::COORD_BITS-1:0];
          e2  <= rest[ritu_pkg::COORD_BITS-1:0];
          if ((req.operation == ritu_pkg::OP_ADD && bad_span) ||
              (req.operation != ritu_pkg::OP_ADD && req.operation != ritu_pkg::OP_READ &&
               req.operation != ritu_pkg::OP_CLEAR))
            status <= ritu_pkg::ST_INVALID;
          else
            status <= ritu_pkg::ST_OK;
        end
      end
      ritu_pkg::S_PLACE: begin
        if (cst.touched) cur <= cst.pos_idx;
        else if (full) status <= ritu_pkg::ST_OVERFLOW;
        else if (pending) begin
          s <= '0;
          e <= e2;
        end
      end
      ritu_pkg::S_ABSORB: begin
        if (!cst.can_absorb && pending) begin
          s <= '0;
          e <= e2;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      rsp_count <= count;
      if (op == ritu_pkg::OP_READ) begin
        rsp_status <= read_ok ? ritu_pkg::ST_OK : ritu_pkg::ST_INVALID;
        rsp_begin  <= read_ok ? cst.rd_lo : '0;
        rsp_end    <= read_ok ? cst.rd_hi : '0;
      end else begin
        rsp_status <= status;
        rsp_begin  <= '0;
        rsp_end    <= '0;
      end
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.interval_count = rsp_count;
  assign rsp.entry_begin    = rsp_begin;
  assign rsp.entry_end      = rsp_end;

  `RITU_ASSERT(a_count_max, clk, rst, count <= ritu_pkg::MAX_COUNT)
  `RITU_ASSERT_NEXT(a_absorb_shrinks, clk, rst, state == ritu_pkg::S_ABSORB && cst.can_absorb, count == $past(count) - 1'b1)
  `RITU_ASSERT_NEXT(a_full_overflow, clk, rst, state == ritu_pkg::S_PLACE && !cst.touched && full, status == ritu_pkg::ST_OVERFLOW && state == ritu_pkg::S_FINISH)
endmodule
`default_nettype wire
